// ----- sv/contact_debounce_qualifier_top_defines.svh -----
// ----------------------------------------------------------------------------
// Contact debounce qualifier assertion macros
// Shared property forms for the checker, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CONTACT_DEBOUNCE_QUALIFIER_TOP_DEFINES_SVH
`define CONTACT_DEBOUNCE_QUALIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define CDQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// Contact debounce qualifier package
// Stream layouts, result record and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	// input transfer layout
	localparam int IN_TDATA_W  = 48;
	localparam int TS_LSB      = 0;
	localparam int LVL_LSB     = 32;
	localparam int SRC_LSB     = 34;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam int RESULT_W    = 147;
	localparam int OUT_TDATA_W = 152;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QUALIFY_MS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_MS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STUCK_MS      = 3'd4;

	localparam logic [31:0] RST_QUALIFY_MS    = 32'd20;
	localparam logic [31:0] RST_RELEASE_MS    = 32'd20;
	localparam logic [31:0] RST_REFRACTORY_MS = 32'd100;
	localparam logic [31:0] RST_STUCK_MS      = 32'd5000;

	localparam logic [1:0] DISP_NONE       = 2'd0;
	localparam logic [1:0] DISP_ACCEPTED   = 2'd1;
	localparam logic [1:0] DISP_SUPPRESSED = 2'd2;

	localparam logic [2:0] QUAL_UNQUALIFIED = 3'd0;
	localparam logic [2:0] QUAL_VALID       = 3'd1;
	localparam logic [2:0] QUAL_STUCK       = 3'd2;
	localparam logic [2:0] QUAL_SOURCE      = 3'd3;
	localparam logic [2:0] QUAL_TIMING      = 3'd4;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_BAD_ARG  = 3'd1;
	localparam logic [2:0] STAT_BAD_CFG  = 3'd2;
	localparam logic [2:0] STAT_NO_INIT  = 3'd3;
	localparam logic [2:0] STAT_SRC_ERR  = 3'd4;

	// first member sits in the top bits
	typedef struct packed {
		logic [31:0] suppressed_count;
		logic [31:0] accepted_count;
		logic [30:0] refractory_left_ms;
		logic [31:0] pulse_width_ms;
		logic [7:0]  fault_code;
		logic [2:0]  status;
		logic [2:0]  quality;
		logic [1:0]  disposition;
		logic        raw_active;
		logic        release_event;
		logic        attack_event;
		logic        qualified_active;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/contact_debounce_qualifier_top.sv -----
// ----------------------------------------------------------------------------
// Contact debounce qualifier
// Time-based debouncer for one contact with refractory, stuck and fault checks.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one timestamped contact sample per transfer; m_* returns one
//   result per sample, in order. cfg_we/cfg_index/cfg_data write the five
//   registers (active level, qualify, release, refractory, stuck) and must
//   only be used while no sample is in flight.
//   A result is offered from the result register: the input register takes
//   the sample at the transfer, and the result register takes its result
//   once the receiver can accept it. Throughput: one sample per cycle while
//   the receiver does not stall; the state update for a sample is
//   combinational subtract/compare logic, so the next sample sees it at once.
//   Reset clears all state; the first sample checks the registers and, if they
//   are out of range, returns an invalid-configuration status until a later
//   sample finds them valid.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more sample; after that s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module contact_debounce_qualifier_top #(
	parameter int TIME_WIDTH = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// timestamp_ms[31:0], raw_level[33:32], source_code[41:34]
	input  wire  [cdq_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// qualified_active[0], attack_event[1], release_event[2], raw_active[3],
	// disposition[5:4], quality[8:6], status[11:9], fault_code[19:12],
	// pulse_width_ms[51:20], refractory_left_ms[82:52],
	// accepted_count[114:83], suppressed_count[146:115]
	output logic [cdq_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  wire                                 cfg_we,
	input  wire  [cdq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [cdq_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import cdq_pkg::*;

	localparam int TW = TIME_WIDTH;
	localparam int CW = (TW > 32) ? TW : 32;
	localparam logic [CW-1:0] HALF_C = CW'(1) << (TW - 1);

	// fields top down as in result_t: everything zero, status not initialized
	localparam result_t HELD_RESET = {32'd0, 32'd0, 31'd0, 32'd0, 8'd0, STAT_NO_INIT,
		QUAL_UNQUALIFIED, DISP_NONE, 4'b0000};

	function automatic logic dur_ok(input logic [31:0] d);
		return (d != 32'd0) && (CW'(d) < HALF_C);
	endfunction

	function automatic logic time_ge(input logic [TW-1:0] e, input logic [31:0] d);
		return CW'(e) >= CW'(d);
	endfunction

	function automatic logic [31:0] lo32(input logic [TW-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		return w[31:0];
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// configuration
	logic        active_level_q;
	logic [31:0] qualify_q, release_q, refractory_q, stuck_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q <= 1'b1;
			qualify_q      <= RST_QUALIFY_MS;
			release_q      <= RST_RELEASE_MS;
			refractory_q   <= RST_REFRACTORY_MS;
			stuck_q        <= RST_STUCK_MS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_LEVEL:  active_level_q <= cfg_data[0];
				REG_QUALIFY_MS:    qualify_q      <= cfg_data;
				REG_RELEASE_MS:    release_q      <= cfg_data;
				REG_REFRACTORY_MS: refractory_q   <= cfg_data;
				REG_STUCK_MS:      stuck_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic          valid_s1;
	logic [TW-1:0] ts_s1;
	logic [1:0]    lvl_s1;
	logic [7:0]    src_s1;
	logic          out_valid_q;
	result_t       out_q;
	logic          advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ts_s1  <= TW'(s_tdata[TS_LSB +: 32]);
			lvl_s1 <= s_tdata[LVL_LSB +: 2];
			src_s1 <= s_tdata[SRC_LSB +: 8];
		end
	end

	// debounce state
	logic          init_q, have_q, cand_on_q, rel_on_q, pulse_open_q, stuck_flag_q, fault_q;
	logic [TW-1:0] last_time_q, cand_start_q, rel_start_q, acc_time_q;
	logic [1:0]    last_lvl_q;
	logic [7:0]    last_src_q, lcode_q;
	logic [2:0]    lstat_q;
	result_t       held_q;

	logic          init_n, have_n, cand_on_n, rel_on_n, pulse_open_n, stuck_n, fault_n;
	logic [TW-1:0] last_time_n, cand_start_n, rel_start_n, acc_time_n;
	logic [1:0]    last_lvl_n;
	logic [7:0]    last_src_n, lcode_n;
	logic [2:0]    lstat_n;
	result_t       held_n;

	logic          cfg_ok, is_act, same;
	logic [TW-1:0] e_last, e_acc, e_rel, e_cand;
	logic [31:0]   refr_full;

	assign cfg_ok = dur_ok(qualify_q) && dur_ok(release_q) &&
		dur_ok(refractory_q) && dur_ok(stuck_q);

	always_comb begin
		// start from live state, or from cleared state on the first valid pass
		init_n = 1'b1;
		if (init_q) begin
			have_n = have_q; cand_on_n = cand_on_q; rel_on_n = rel_on_q;
			pulse_open_n = pulse_open_q; stuck_n = stuck_flag_q; fault_n = fault_q;
			last_time_n = last_time_q; cand_start_n = cand_start_q;
			rel_start_n = rel_start_q; acc_time_n = acc_time_q;
			last_lvl_n = last_lvl_q; last_src_n = last_src_q;
			lcode_n = lcode_q; lstat_n = lstat_q; held_n = held_q;
		end else begin
			have_n = 1'b0; cand_on_n = 1'b0; rel_on_n = 1'b0;
			pulse_open_n = 1'b0; stuck_n = 1'b0; fault_n = 1'b0;
			last_time_n = '0; cand_start_n = '0; rel_start_n = '0; acc_time_n = '0;
			last_lvl_n = '0; last_src_n = '0; lcode_n = '0; lstat_n = '0;
			held_n = '0;
		end

		is_act    = (lvl_s1 == {1'b0, active_level_q});
		e_last    = ts_s1 - last_time_n;
		same      = (lvl_s1 == last_lvl_n) && (src_s1 == last_src_n);
		e_acc     = ts_s1 - acc_time_n;
		e_rel     = '0;
		e_cand    = '0;
		refr_full = '0;

		if (have_n && (e_last[TW-1] || (e_last == '0 && !same))) begin
			// timing fault: sample is not remembered
			held_n.attack_event  = 1'b0;
			held_n.release_event = 1'b0;
			held_n.disposition   = DISP_NONE;
			held_n.raw_active    = is_act;
			held_n.quality       = QUAL_TIMING;
			held_n.status        = STAT_BAD_ARG;
		end else if (have_n && e_last == '0) begin
			// repeated sample: hold previous result
		end else begin
			held_n.attack_event  = 1'b0;
			held_n.release_event = 1'b0;
			held_n.disposition   = DISP_NONE;
			have_n      = 1'b1;
			last_time_n = ts_s1;
			last_lvl_n  = lvl_s1;
			last_src_n  = src_s1;
			if (lvl_s1[1]) begin
				held_n.quality = QUAL_SOURCE;
				held_n.status  = STAT_BAD_ARG;
				lstat_n = STAT_BAD_ARG;
				fault_n = 1'b1;
			end else begin
				held_n.raw_active = is_act;
				if (fault_n) begin
					held_n.quality = QUAL_SOURCE;
					held_n.status  = lstat_n;
				end else if (src_s1 != 8'd0) begin
					held_n.quality = QUAL_SOURCE;
					held_n.status  = STAT_SRC_ERR;
					lstat_n = STAT_SRC_ERR;
					lcode_n = src_s1;
					fault_n = 1'b1;
				end else begin
					held_n.quality = stuck_n ? QUAL_STUCK : QUAL_VALID;
					held_n.status  = STAT_OK;
					if (!held_n.qualified_active) begin
						rel_on_n = 1'b0;
						if (!is_act) begin
							cand_on_n = 1'b0;
						end else if (!cand_on_n) begin
							cand_on_n = 1'b1;
							cand_start_n = ts_s1;
						end
					end else begin
						cand_on_n = 1'b0;
						if (is_act) begin
							rel_on_n = 1'b0;
						end else if (!rel_on_n) begin
							rel_on_n = 1'b1;
							rel_start_n = ts_s1;
						end
					end
					e_rel  = ts_s1 - rel_start_n;
					e_cand = ts_s1 - cand_start_n;
					if (held_n.accepted_count == 32'd0 || time_ge(e_acc, refractory_q)) begin
						refr_full = 32'd0;
					end else begin
						refr_full = refractory_q - lo32(e_acc);
					end
					held_n.refractory_left_ms = refr_full[30:0];

					if (held_n.qualified_active && rel_on_n && time_ge(e_rel, release_q)) begin
						held_n.qualified_active = 1'b0;
						held_n.release_event    = 1'b1;
						held_n.quality          = QUAL_VALID;
						rel_on_n = 1'b0;
						stuck_n  = 1'b0;
						if (pulse_open_n) begin
							held_n.pulse_width_ms = lo32(e_acc);
							pulse_open_n = 1'b0;
						end
					end else if (held_n.qualified_active && pulse_open_n &&
						time_ge(e_acc, stuck_q)) begin
						held_n.quality = QUAL_STUCK;
						stuck_n = 1'b1;
					end else if (!held_n.qualified_active && cand_on_n &&
						time_ge(e_cand, qualify_q)) begin
						held_n.qualified_active = 1'b1;
						held_n.attack_event     = 1'b1;
						cand_on_n = 1'b0;
						if (refr_full != 32'd0) begin
							held_n.suppressed_count = sat_inc(held_n.suppressed_count);
							held_n.disposition      = DISP_SUPPRESSED;
						end else begin
							acc_time_n   = ts_s1;
							pulse_open_n = 1'b1;
							held_n.accepted_count     = sat_inc(held_n.accepted_count);
							held_n.disposition        = DISP_ACCEPTED;
							held_n.refractory_left_ms = refractory_q[30:0];
						end
					end
				end
			end
		end

		// registers out of range before the first pass: report and change nothing else
		if (!init_q && !cfg_ok) begin
			init_n = 1'b0;
			have_n = have_q; cand_on_n = cand_on_q; rel_on_n = rel_on_q;
			pulse_open_n = pulse_open_q; stuck_n = stuck_flag_q; fault_n = fault_q;
			last_time_n = last_time_q; cand_start_n = cand_start_q;
			rel_start_n = rel_start_q; acc_time_n = acc_time_q;
			last_lvl_n = last_lvl_q; last_src_n = last_src_q;
			lcode_n = lcode_q; lstat_n = lstat_q;
			held_n = held_q;
			held_n.status = STAT_BAD_CFG;
		end

		held_n.fault_code = (held_n.status == STAT_SRC_ERR) ? lcode_n : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0; have_q <= 1'b0; cand_on_q <= 1'b0; rel_on_q <= 1'b0;
			pulse_open_q <= 1'b0; stuck_flag_q <= 1'b0; fault_q <= 1'b0;
			last_time_q <= '0; cand_start_q <= '0; rel_start_q <= '0; acc_time_q <= '0;
			last_lvl_q <= '0; last_src_q <= '0; lcode_q <= '0; lstat_q <= '0;
			held_q <= HELD_RESET;
		end else if (advance) begin
			init_q <= init_n; have_q <= have_n; cand_on_q <= cand_on_n;
			rel_on_q <= rel_on_n; pulse_open_q <= pulse_open_n; stuck_flag_q <= stuck_n;
			fault_q <= fault_n; last_time_q <= last_time_n; cand_start_q <= cand_start_n;
			rel_start_q <= rel_start_n; acc_time_q <= acc_time_n;
			last_lvl_q <= last_lvl_n; last_src_q <= last_src_n;
			lcode_q <= lcode_n; lstat_q <= lstat_n; held_q <= held_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= held_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

endmodule

`default_nettype wire

// ----- sv/cdq_checker.sv -----
// ----------------------------------------------------------------------------
// Contact debounce qualifier port checker
// Watches the result stream for consistency of events, dispositions and codes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "contact_debounce_qualifier_top_defines.svh"

module cdq_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [cdq_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import cdq_pkg::*;

	result_t r;
	assign r = m_tdata[RESULT_W-1:0];

	// stalled result must hold
	`CDQ_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// attack leaves the contact active, release leaves it inactive
	`CDQ_ASSERT_NOW(a_attack, m_tvalid && r.attack_event, r.qualified_active && !r.release_event, "attack without active state")
	`CDQ_ASSERT_NOW(a_release, m_tvalid && r.release_event, !r.qualified_active, "release with active state")

	// a disposition only comes with an attack
	`CDQ_ASSERT_NOW(a_disp, m_tvalid && r.disposition != DISP_NONE, r.attack_event, "disposition without attack")

	// fault code only shown with source-error status
	`CDQ_ASSERT_NOW(a_code, m_tvalid && r.fault_code != 8'd0, r.status == STAT_SRC_ERR, "fault code without source error")

endmodule

bind contact_debounce_qualifier_top cdq_checker u_cdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/contact_debounce_qualifier_top_test.sv -----
// ----------------------------------------------------------------------------
// Contact debounce qualifier testbench
// Streams timestamped contact samples into the debouncer under random
// stalls on both sides, predicts every result in step and compares each
// returned result field by field. Covers invalid configuration before
// start-up, attack, release, refractory suppression, stuck detection, time
// wrap, timing faults, repeated samples and latched source faults.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module contact_debounce_qualifier_top_test;

	import cdq_pkg::*;

	localparam int CYCLE_LIMIT = 150000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// timestamp_ms, raw_level, source_code from bit 0 up
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// result_t fields from qualified_active at bit 0 up to suppressed_count
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	contact_debounce_qualifier_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Debouncer prediction: registers, working state, held result
	// ------------------------------------------------------------------
	logic        cfg_active_level = 1'b1;
	logic [31:0] cfg_qualify      = RST_QUALIFY_MS;
	logic [31:0] cfg_release      = RST_RELEASE_MS;
	logic [31:0] cfg_refractory   = RST_REFRACTORY_MS;
	logic [31:0] cfg_stuck        = RST_STUCK_MS;

	bit          st_initialized = 1'b0;
	bit          st_have_last = 1'b0;
	bit          st_candidate_on = 1'b0;
	bit          st_release_on = 1'b0;
	bit          st_pulse_open = 1'b0;
	bit          st_stuck = 1'b0;
	bit          st_fault = 1'b0;
	logic [31:0] st_last_time = '0;
	logic [31:0] st_candidate_start = '0;
	logic [31:0] st_release_start = '0;
	logic [31:0] st_accept_time = '0;
	logic [1:0]  st_last_level = '0;
	logic [7:0]  st_last_source = '0;
	logic [2:0]  st_latched_status = STAT_OK;
	logic [7:0]  st_latched_code = '0;

	logic        h_qa = 1'b0;
	logic        h_atk = 1'b0;
	logic        h_rel = 1'b0;
	logic        h_ract = 1'b0;
	logic [1:0]  h_disp = DISP_NONE;
	logic [2:0]  h_qual = QUAL_UNQUALIFIED;
	logic [2:0]  h_stat = STAT_NO_INIT;
	logic [31:0] h_pulse = '0;
	logic [31:0] h_refr = '0;
	logic [31:0] h_acc = '0;
	logic [31:0] h_sup = '0;

	result_t pending_results[$];

	function automatic bit duration_ok(input logic [31:0] d);
		return d != 32'd0 && !d[31];
	endfunction

	function automatic logic [31:0] count_up(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void clear_state();
		st_have_last = 1'b0;
		st_candidate_on = 1'b0;
		st_release_on = 1'b0;
		st_pulse_open = 1'b0;
		st_stuck = 1'b0;
		st_fault = 1'b0;
		st_last_time = '0;
		st_candidate_start = '0;
		st_release_start = '0;
		st_accept_time = '0;
		st_last_level = '0;
		st_last_source = '0;
		st_latched_status = STAT_OK;
		st_latched_code = '0;
		h_qa = 1'b0;
		h_atk = 1'b0;
		h_rel = 1'b0;
		h_ract = 1'b0;
		h_disp = DISP_NONE;
		h_qual = QUAL_UNQUALIFIED;
		h_stat = STAT_OK;
		h_pulse = '0;
		h_refr = '0;
		h_acc = '0;
		h_sup = '0;
	endfunction

	function automatic void update_refractory(input logic [31:0] now_ms);
		logic [31:0] e;
		if (h_acc == 32'd0) begin
			h_refr = '0;
			return;
		end
		e = now_ms - st_accept_time;
		h_refr = (e >= cfg_refractory) ? 32'd0 : cfg_refractory - e;
	endfunction

	function automatic void flag_timing(input logic [1:0] lvl);
		h_atk = 1'b0;
		h_rel = 1'b0;
		h_disp = DISP_NONE;
		h_ract = (lvl == {1'b0, cfg_active_level});
		h_qual = QUAL_TIMING;
		h_stat = STAT_BAD_ARG;
	endfunction

	function automatic void note_sample(input logic [31:0] t, input logic [1:0] lvl,
			input logic [7:0] src);
		st_have_last = 1'b1;
		st_last_time = t;
		st_last_level = lvl;
		st_last_source = src;
	endfunction

	function automatic void apply_sample(input logic [31:0] t, input logic [1:0] lvl,
			input logic [7:0] src);
		logic [31:0] e;
		if (st_have_last) begin
			e = t - st_last_time;
			if (e[31]) begin
				flag_timing(lvl);
				return;
			end
			if (e == 32'd0) begin
				if (lvl == st_last_level && src == st_last_source)
					return;
				flag_timing(lvl);
				return;
			end
		end
		h_atk = 1'b0;
		h_rel = 1'b0;
		h_disp = DISP_NONE;
		if (lvl > 2'd1) begin
			h_qual = QUAL_SOURCE;
			h_stat = STAT_BAD_ARG;
			st_latched_status = STAT_BAD_ARG;
			st_fault = 1'b1;
			note_sample(t, lvl, src);
			return;
		end
		h_ract = (lvl[0] == cfg_active_level);
		if (st_fault) begin
			h_qual = QUAL_SOURCE;
			h_stat = st_latched_status;
			note_sample(t, lvl, src);
			return;
		end
		if (src != 8'd0) begin
			h_qual = QUAL_SOURCE;
			h_stat = STAT_SRC_ERR;
			st_latched_status = STAT_SRC_ERR;
			st_latched_code = src;
			st_fault = 1'b1;
			note_sample(t, lvl, src);
			return;
		end
		note_sample(t, lvl, src);
		h_qual = st_stuck ? QUAL_STUCK : QUAL_VALID;
		h_stat = STAT_OK;
		if (!h_qa) begin
			st_release_on = 1'b0;
			if (!h_ract)
				st_candidate_on = 1'b0;
			else if (!st_candidate_on) begin
				st_candidate_on = 1'b1;
				st_candidate_start = t;
			end
		end else begin
			st_candidate_on = 1'b0;
			if (h_ract)
				st_release_on = 1'b0;
			else if (!st_release_on) begin
				st_release_on = 1'b1;
				st_release_start = t;
			end
		end
		update_refractory(t);
		if (h_qa && st_release_on && (t - st_release_start) >= cfg_release) begin
			h_qa = 1'b0;
			h_rel = 1'b1;
			st_release_on = 1'b0;
			st_stuck = 1'b0;
			h_qual = QUAL_VALID;
			if (st_pulse_open) begin
				h_pulse = t - st_accept_time;
				st_pulse_open = 1'b0;
			end
			return;
		end
		if (h_qa && st_pulse_open && (t - st_accept_time) >= cfg_stuck) begin
			h_qual = QUAL_STUCK;
			st_stuck = 1'b1;
			return;
		end
		if (!h_qa && st_candidate_on && (t - st_candidate_start) >= cfg_qualify) begin
			h_qa = 1'b1;
			h_atk = 1'b1;
			st_candidate_on = 1'b0;
			// attack inside the refractory window bumps the suppressed count instead of the accepted count
			if (h_refr != 32'd0) begin
				h_sup = count_up(h_sup);
				h_disp = DISP_SUPPRESSED;
				return;
			end
			st_accept_time = t;
			st_pulse_open = 1'b1;
			h_acc = count_up(h_acc);
			h_disp = DISP_ACCEPTED;
			update_refractory(t);
		end
	endfunction

	function automatic result_t debounce_sample(input logic [31:0] t, input logic [1:0] lvl,
			input logic [7:0] src);
		result_t r;
		if (!st_initialized) begin
			if (duration_ok(cfg_qualify) && duration_ok(cfg_release) &&
					duration_ok(cfg_refractory) && duration_ok(cfg_stuck)) begin
				st_initialized = 1'b1;
				clear_state();
				apply_sample(t, lvl, src);
			end else
				h_stat = STAT_BAD_CFG;
		end else
			apply_sample(t, lvl, src);
		r.qualified_active   = h_qa;
		r.attack_event       = h_atk;
		r.release_event      = h_rel;
		r.raw_active         = h_ract;
		r.disposition        = h_disp;
		r.quality            = h_qual;
		r.status             = h_stat;
		r.fault_code         = (h_stat == STAT_SRC_ERR) ? st_latched_code : 8'd0;
		r.pulse_width_ms     = h_pulse;
		r.refractory_left_ms = h_refr[30:0];
		r.accepted_count     = h_acc;
		r.suppressed_count   = h_sup;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	int mismatches = 0;
	int results_seen = 0;
	int cycle_count = 0;

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("result %0d %s: expected %0h, got %0h", results_seen, what, want, got);
	endtask

	task automatic compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			report_mismatch(what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[RESULT_W-1:0];
			if (pending_results.size() == 0)
				report_mismatch("pending results", 32'd1, 32'd0);
			else begin
				want = pending_results.pop_front();
				compare_field("qualified_active", 32'(want.qualified_active),
					32'(got.qualified_active));
				compare_field("attack_event", 32'(want.attack_event), 32'(got.attack_event));
				compare_field("release_event", 32'(want.release_event),
					32'(got.release_event));
				compare_field("raw_active", 32'(want.raw_active), 32'(got.raw_active));
				compare_field("disposition", 32'(want.disposition), 32'(got.disposition));
				compare_field("quality", 32'(want.quality), 32'(got.quality));
				compare_field("status", 32'(want.status), 32'(got.status));
				compare_field("fault_code", 32'(want.fault_code), 32'(got.fault_code));
				compare_field("pulse_width_ms", want.pulse_width_ms, got.pulse_width_ms);
				compare_field("refractory_left_ms", 32'(want.refractory_left_ms),
					32'(got.refractory_left_ms));
				compare_field("accepted_count", want.accepted_count, got.accepted_count);
				compare_field("suppressed_count", want.suppressed_count,
					got.suppressed_count);
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stall bursts and long hold-offs
	// ------------------------------------------------------------------
	bit idle_en = 1'b1;
	int hold_request = 0;
	int hold_left = 0;
	int sink_gap = 0;

	always @(negedge clk) begin : result_sink
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (sink_gap != 0) begin
			sink_gap--;
			m_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			sink_gap = $urandom_range(0, 4);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// Sample side
	// ------------------------------------------------------------------
	logic [31:0] clock_ms = '0;
	logic        contact_level = 1'b0;

	task automatic send_sample(input logic [31:0] ts, input logic [1:0] lvl,
			input logic [7:0] src);
		logic [IN_TDATA_W-1:0] word;
		int gap;
		if (idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		word = '0;
		word[TS_LSB +: 32] = ts;
		word[LVL_LSB +: 2] = lvl;
		word[SRC_LSB +: 8] = src;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		pending_results.push_back(debounce_sample(ts, lvl, src));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// write only once every sample in flight has come back
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		drain_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ACTIVE_LEVEL:  cfg_active_level = value[0];
			REG_QUALIFY_MS:    cfg_qualify = value;
			REG_RELEASE_MS:    cfg_release = value;
			REG_REFRACTORY_MS: cfg_refractory = value;
			REG_STUCK_MS:      cfg_stuck = value;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [31:0] level_word, input logic [31:0] qualify,
			input logic [31:0] release_d, input logic [31:0] refractory,
			input logic [31:0] stuck);
		write_reg(REG_ACTIVE_LEVEL, level_word);
		write_reg(REG_QUALIFY_MS, qualify);
		write_reg(REG_RELEASE_MS, release_d);
		write_reg(REG_REFRACTORY_MS, refractory);
		write_reg(REG_STUCK_MS, stuck);
	endtask

	// Bouncing contact with time moving forward; noise_pct percent of samples
	// are repeats, same-time clashes, backward or half-range jumps, long gaps.
	task automatic run_contact(input int count, input logic [31:0] max_step,
			input int flip_odds, input int noise_pct);
		int pick;
		logic [31:0] ts;
		logic [1:0] lvl;
		logic [7:0] src;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			src = 8'h00;
			lvl = {1'b0, contact_level};
			if (pick >= noise_pct) begin
				if ($urandom_range(0, flip_odds) == 0)
					contact_level = ~contact_level;
				lvl = {1'b0, contact_level};
				if ($urandom_range(0, 39) == 0)
					clock_ms += $urandom_range(1, 32'h7FFF_FFFF);
				else
					clock_ms += $urandom_range(1, max_step);
				ts = clock_ms;
			end else begin
				case (pick % 5)
					0: ts = clock_ms;
					1: begin
						ts = clock_ms;
						lvl = 2'($urandom_range(0, 3));
						src = 8'($urandom_range(0, 255));
						if (lvl == {1'b0, contact_level} && src == 8'h00)
							lvl = lvl ^ 2'b10;
					end
					2: begin
						ts = clock_ms - $urandom_range(1, 2000);
						lvl = 2'($urandom_range(0, 3));
						src = 8'($urandom_range(0, 255));
					end
					3: begin
						ts = clock_ms + 32'h8000_0000 + $urandom_range(0, 1000);
						lvl = 2'($urandom_range(0, 3));
						src = 8'($urandom_range(0, 255));
					end
					default: begin
						clock_ms += 32'h7FFF_FFFF - $urandom_range(0, 3);
						ts = clock_ms;
					end
				endcase
			end
			send_sample(ts, lvl, src);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_invalid_config();
		write_reg(REG_QUALIFY_MS, 32'd0);
		send_sample($urandom(), 2'd1, 8'h00);
		write_reg(REG_QUALIFY_MS, RST_QUALIFY_MS);
		write_reg(REG_RELEASE_MS, 32'h8000_0000);
		send_sample($urandom(), 2'd0, 8'h00);
		write_reg(REG_RELEASE_MS, RST_RELEASE_MS);
		write_reg(REG_REFRACTORY_MS, 32'hFFFF_FFFF);
		send_sample($urandom(), 2'd1, 8'h00);
		write_reg(REG_REFRACTORY_MS, RST_REFRACTORY_MS);
		write_reg(REG_STUCK_MS, 32'd0);
		send_sample($urandom(), 2'd3, 8'hFF);
		write_reg(REG_STUCK_MS, RST_STUCK_MS);
	endtask

	// default registers; base sits just below the wrap point
	task automatic test_directed_timing();
		logic [31:0] base;
		base = 32'hFFFF_FFC0;
		send_sample(base, 2'd0, 8'h00);
		send_sample(base + 32'd10, 2'd1, 8'h00);
		send_sample(base + 32'd10, 2'd1, 8'h00);
		send_sample(base + 32'd10, 2'd0, 8'h00);
		send_sample(base + 32'd25, 2'd1, 8'h00);
		send_sample(base + 32'd30, 2'd1, 8'h00);
		send_sample(base + 32'd40, 2'd0, 8'h00);
		send_sample(base + 32'd65, 2'd0, 8'h00);
		// attack inside the refractory window
		send_sample(base + 32'd70, 2'd1, 8'h00);
		send_sample(base + 32'd95, 2'd1, 8'h00);
		send_sample(base + 32'd100, 2'd0, 8'h00);
		send_sample(base + 32'd125, 2'd0, 8'h00);
		send_sample(base + 32'd300, 2'd1, 8'h00);
		send_sample(base + 32'd330, 2'd1, 8'h00);
		// held past the stuck limit
		send_sample(base + 32'd5430, 2'd1, 8'h00);
		send_sample(base + 32'd5440, 2'd1, 8'h00);
		send_sample(base + 32'd5435, 2'd1, 8'h00);
		send_sample(base + 32'd5440 + 32'h8000_0000, 2'd3, 8'hFF);
		clock_ms = base + 32'd5440 + 32'h7FFF_FFFF;
		send_sample(clock_ms, 2'd0, 8'h00);
		clock_ms += 32'd20;
		send_sample(clock_ms, 2'd0, 8'h00);
		contact_level = 1'b0;
	endtask

	task automatic test_register_settings();
		apply_settings(32'd1, 32'd3, 32'd4, 32'd25, 32'd50);
		run_contact(250, 32'd10, 5, 8);
		apply_settings(32'hFFFF_FFFE, 32'd1, 32'd1, 32'd1, 32'd1);
		run_contact(200, 32'd3, 3, 8);
		apply_settings(32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
		run_contact(150, 32'd5, 3, 8);
		apply_settings(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF);
		run_contact(150, 32'h3FFF_FFFF, 3, 8);
		// refractory window that never runs out
		apply_settings(32'd0, 32'd2, 32'd2, 32'hFFFF_FFFF, 32'h8000_0000);
		run_contact(150, 32'd40, 4, 8);
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_UNUSED, $urandom());
			apply_settings($urandom(), $urandom_range(1, 40), $urandom_range(1, 40),
				$urandom_range(1, 200), $urandom_range(1, 400));
			run_contact(150, 32'd20, 5, 8);
		end
	endtask

	task automatic test_backpressure();
		apply_settings(32'd1, 32'd5, 32'd5, 32'd40, 32'd300);
		// hold off the result side so the input register fills and stalls
		hold_request = 200;
		run_contact(60, 32'd10, 5, 5);
		// pause the sample side until every result is back
		drain_results();
		run_contact(40, 32'd10, 5, 5);
	endtask

	task automatic test_fault_latch();
		logic [7:0] code;
		idle_en = 1'b0;
		run_contact(150, 32'd10, 5, 8);
		clock_ms += 32'd10;
		send_sample(clock_ms, 2'd1, 8'h00);
		clock_ms += 32'd10;
		code = 8'($urandom_range(1, 255));
		send_sample(clock_ms, 2'd0, code);
		clock_ms += 32'd10;
		send_sample(clock_ms, 2'd1, 8'hFF);
		clock_ms += 32'd10;
		send_sample(clock_ms, 2'd0, 8'h00);
		send_sample(clock_ms, 2'd0, 8'h00);
		send_sample(clock_ms, 2'd1, 8'h00);
		// invalid level overrides the latched source status
		clock_ms += 32'd10;
		send_sample(clock_ms, 2'd2, 8'h00);
		clock_ms += 32'd10;
		send_sample(clock_ms, 2'd3, 8'h55);
		clock_ms += 32'd10;
		send_sample(clock_ms, 2'd1, 8'h00);
		clock_ms += 32'd10;
		send_sample(clock_ms, 2'd0, 8'hAA);
		for (int i = 0; i < 30; i++) begin
			clock_ms += $urandom_range(1, 30);
			code = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'h00;
			send_sample(clock_ms, 2'($urandom_range(0, 3)), code);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_invalid_config();
		test_directed_timing();
		test_register_settings();
		test_backpressure();
		test_fault_latch();
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
